// ===== rtl/tst_pkg.sv =====
// Package for the task slot table: item structs, slot record, opcode and state codes.
// No dependencies.
package tst_pkg;

    localparam int ID_W   = 31;
    localparam int NAME_W = 56;
    localparam int ST_W   = 3;
    localparam int OP_W   = 3;
    localparam int CNT_W  = 5;

    localparam logic [ID_W-1:0] ID_START = ID_W'(100);

    localparam logic [OP_W-1:0] OP_CREATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_KILL    = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEANUP = 3'd2;
    localparam logic [OP_W-1:0] OP_GET     = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd4;
    localparam logic [OP_W-1:0] OP_COUNT   = 3'd5;

    localparam logic [ST_W-1:0] ST_UNUSED  = 3'd0;
    localparam logic [ST_W-1:0] ST_RUNNING = 3'd1;
    localparam logic [ST_W-1:0] ST_ZOMBIE  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [ID_W-1:0]   task_id;
        logic [ID_W-1:0]   parent_id;
        logic [NAME_W-1:0] task_name;
    } t_task_in;

    typedef struct packed {
        logic              status;
        logic [ID_W-1:0]   id_out;
        logic [ID_W-1:0]   parent_out;
        logic [ST_W-1:0]   state_out;
        logic [NAME_W-1:0] name_out;
        logic [CNT_W-1:0]  live_count;
    } t_task_out;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   parent;
        logic [ST_W-1:0]   state;
        logic [NAME_W-1:0] name;
    } t_slot;

endpackage

// ===== rtl/task_slot_table.sv =====
// Task slot table: slot records in a memory, used flags in flops, one slot checked per cycle.
// Depends on tst_pkg.
// Scan end: a hit on slot k ends the scan at that slot; a miss, a count or an unused
// opcode checks all SLOTS slots. Each slot record is read, then checked; the result is registered.
// Throughput: one item per scan; start is taken again in the cycle the result shows.
// Rate is set by the single memory read port, one slot record per cycle.
// Reset: used flags cleared, id counter to 100, no result pending; the receiver cannot stall.
module task_slot_table #(
    parameter int SLOTS      = 16,
    parameter int NAME_BYTES = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  tst_pkg::t_task_in  i_item,
    output logic               busy,
    output logic               o_done,
    output tst_pkg::t_task_out o_result
);
    import tst_pkg::*;

    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW   = $clog2(SLOTS + 1);
    localparam int CUTN = NAME_BYTES - 1;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    function automatic logic [NAME_W-1:0] f_cut(input logic [NAME_W-1:0] v, input int lim);
        logic [NAME_W-1:0] r;
        logic              stop;
        r    = '0;
        stop = 1'b0;
        for (int i = 0; i < 7; i++) begin
            if (v[8*i +: 8] == 8'd0 || i >= lim) begin
                stop = 1'b1;
            end
            if (!stop) begin
                r[8*i +: 8] = v[8*i +: 8];
            end
        end
        return r;
    endfunction

    t_slot r_mem [SLOTS];
    t_slot r_rd;

    t_state          r_state, n_state;
    logic [IW:0]     r_idx, n_idx;
    logic [IW-1:0]   r_chk_idx, n_chk_idx;
    logic            r_chk_vld, n_chk_vld;
    logic [SLOTS-1:0] r_used, n_used;
    logic [ID_W-1:0] r_id_ctr, n_id_ctr;
    logic [CW-1:0]   r_cnt, n_cnt;
    t_task_in        r_req, n_req;
    logic            r_done, n_done;
    t_task_out       r_res, n_res;

    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    t_slot           mem_wdata;

    logic            issue;
    logic            used_chk;
    logic            hit;
    logic            last;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[r_idx[IW-1:0]];
    end

    always_comb begin
        issue    = r_idx < (IW+1)'(SLOTS);
        used_chk = r_used[r_chk_idx];
        last     = r_chk_idx == IW'(SLOTS - 1);
        case (r_req.opcode)
            OP_CREATE:  hit = !used_chk;
            OP_KILL:    hit = used_chk && r_rd.id == r_req.task_id;
            OP_GET:     hit = used_chk && r_rd.id == r_req.task_id;
            OP_CLEANUP: hit = used_chk && r_rd.id == r_req.task_id && r_rd.state == ST_ZOMBIE;
            OP_FIND:    hit = used_chk && r_rd.name == r_req.task_name;
            default:    hit = 1'b0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_chk_idx = r_chk_idx;
        n_chk_vld = 1'b0;
        n_used    = r_used;
        n_id_ctr  = r_id_ctr;
        n_cnt     = r_cnt;
        n_req     = r_req;
        n_done    = 1'b0;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_chk_idx;
        mem_wdata = r_rd;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req           = i_item;
                    n_req.task_name = (i_item.opcode == OP_CREATE) ?
                                      f_cut(i_item.task_name, CUTN) :
                                      f_cut(i_item.task_name, 7);
                    n_idx   = '0;
                    n_cnt   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue) begin
                    n_idx     = r_idx + 1'b1;
                    n_chk_idx = r_idx[IW-1:0];
                    n_chk_vld = 1'b1;
                end
                if (r_chk_vld) begin
                    if (used_chk) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (hit || last) begin
                        n_state          = S_IDLE;
                        n_done           = 1'b1;
                        n_res            = '0;
                        n_res.status     = 1'b1;
                        n_chk_vld        = 1'b0;
                    end
                    if (hit) begin
                        n_res.status = 1'b0;
                        case (r_req.opcode)
                            OP_CREATE: begin
                                mem_we            = 1'b1;
                                mem_wdata.id      = r_id_ctr;
                                mem_wdata.parent  = r_req.parent_id;
                                mem_wdata.state   = ST_RUNNING;
                                mem_wdata.name    = r_req.task_name;
                                n_used[r_chk_idx] = 1'b1;
                                n_id_ctr          = r_id_ctr + 1'b1;
                                n_res.id_out      = r_id_ctr;
                            end
                            OP_KILL: begin
                                mem_we          = 1'b1;
                                mem_wdata.state = ST_ZOMBIE;
                            end
                            OP_CLEANUP: begin
                                mem_we            = 1'b1;
                                mem_wdata         = '0;
                                mem_wdata.state   = ST_UNUSED;
                                n_used[r_chk_idx] = 1'b0;
                            end
                            OP_GET: begin
                                n_res.id_out     = r_rd.id;
                                n_res.parent_out = r_rd.parent;
                                n_res.state_out  = r_rd.state;
                                n_res.name_out   = r_rd.name;
                            end
                            OP_FIND: begin
                                n_res.id_out = r_rd.id;
                            end
                            default: begin
                                n_res.status = 1'b1;
                            end
                        endcase
                    end else if (last && r_req.opcode == OP_COUNT) begin
                        n_res.status     = 1'b0;
                        n_res.live_count = (32'(n_cnt) > 32'd31) ? CNT_W'(31) : CNT_W'(n_cnt);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_chk_idx <= '0;
            r_chk_vld <= 1'b0;
            r_used    <= '0;
            r_id_ctr  <= ID_START;
            r_cnt     <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_chk_idx <= n_chk_idx;
            r_chk_vld <= n_chk_vld;
            r_used    <= n_used;
            r_id_ctr  <= n_id_ctr;
            r_cnt     <= n_cnt;
            r_done    <= n_done;
        end
        r_req <= n_req;
        r_res <= n_res;
    end

    assign busy     = r_state != S_IDLE;
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
